// ===== src/mwo_pkg.sv =====
// Shared types, constants and the sine table function of the waveform oscillator.
`timescale 1ns / 1ps

package mwo_pkg;

    localparam logic [63:0] Q30_ONE         = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30     = 64'd1686629713;
    localparam logic [21:0] INV_TWO_PI_Q24  = 22'd2670177;
    localparam logic [15:0] TWO_OVER_PI_Q16 = 16'd41722;

    typedef enum logic [2:0] {
        WAVE_SINE     = 3'd0,
        WAVE_SQUARE   = 3'd1,
        WAVE_TRIANGLE = 3'd2,
        WAVE_SAW      = 3'd3,
        WAVE_PULSE    = 3'd4
    } t_wave;

    typedef enum logic [2:0] {
        REG_WAVEFORM  = 3'd0,
        REG_FREQUENCY = 3'd1,
        REG_AMPLITUDE = 3'd2,
        REG_OFFSET    = 3'd3,
        REG_MOD_FREQ  = 3'd4,
        REG_MOD_DEPTH = 3'd5,
        REG_DUTY      = 3'd6,
        REG_HARMONICS = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [2:0]         waveform;
        logic [21:0]        frequency;
        logic [14:0]        amplitude;
        logic signed [15:0] offset;
        logic [21:0]        mod_frequency;
        logic [23:0]        mod_depth;
        logic [15:0]        duty;
        logic [5:0]         harmonics;
    } t_cfg;

    // One sine table entry in Q16, built from a Taylor series over a folded quarter wave.
    function automatic logic signed [17:0] sin_entry(input int unsigned k, input int unsigned tb);
        logic [63:0] q;
        logic [63:0] quad;
        logic [63:0] r;
        logic [63:0] rr;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] v;
        q    = 64'd1 << (tb - 2);
        quad = 64'(k) >> (tb - 2);
        r    = 64'(k) & (q - 64'd1);
        rr   = quad[0] ? (q - r) : r;
        x    = (rr * HALF_PI_Q30) >> (tb - 2);
        x2   = (x * x) >> 30;
        t    = Q30_ONE;
        t    = Q30_ONE - ((x2 * t) >> 30) / 110;
        t    = Q30_ONE - ((x2 * t) >> 30) / 72;
        t    = Q30_ONE - ((x2 * t) >> 30) / 42;
        t    = Q30_ONE - ((x2 * t) >> 30) / 20;
        t    = Q30_ONE - ((x2 * t) >> 30) / 6;
        v    = (((x * t) >> 30) + 64'd8192) >> 14;
        if (v > 64'd65536) begin
            v = 64'd65536;
        end
        if (quad >= 64'd2) begin
            return -$signed(v[17:0]);
        end
        return $signed(v[17:0]);
    endfunction

endpackage

// ===== src/mwo_mul.sv =====
// Shared registered multiplier: unsigned 32-bit by signed 25-bit operand.
`timescale 1ns / 1ps

module mwo_mul (
    input  logic               i_clk,
    input  logic [31:0]        i_a,
    input  logic signed [24:0] i_b,
    output logic signed [57:0] o_p
);

    logic signed [57:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 58'($signed({1'b0, i_a}) * i_b);
    end

    assign o_p = r_p;

endmodule

// ===== src/mwo_sine_rom.sv =====
// Constant sine table with a registered read port.
`timescale 1ns / 1ps

module mwo_sine_rom #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                       i_clk,
    input  logic [SINE_TABLE_BITS-1:0] i_addr,
    output logic signed [17:0]         o_data
);

    localparam int TabSize = 1 << SINE_TABLE_BITS;

    logic signed [17:0] w_tab [TabSize];
    logic signed [17:0] r_data;

    for (genvar g = 0; g < TabSize; g++) begin : g_tab
        assign w_tab[g] = mwo_pkg::sin_entry(g, SINE_TABLE_BITS);
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_tab[i_addr];
    end

    assign o_data = r_data;

endmodule

// ===== src/mwo_apb_regs.sv =====
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module mwo_apb_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [4:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    output logic [31:0]        o_prdata,
    output logic               o_pready,
    output mwo_pkg::t_cfg      o_cfg
);

    mwo_pkg::t_cfg     r_cfg;
    mwo_pkg::t_reg_idx w_idx;
    logic              w_wr;

    assign w_idx    = mwo_pkg::t_reg_idx'(i_paddr[4:2]);
    assign w_wr     = i_psel & i_penable & i_pwrite;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.waveform      <= 3'd0;
            r_cfg.frequency     <= 22'd112640;
            r_cfg.amplitude     <= 15'd16384;
            r_cfg.offset        <= 16'sd0;
            r_cfg.mod_frequency <= 22'd0;
            r_cfg.mod_depth     <= 24'd0;
            r_cfg.duty          <= 16'd32768;
            r_cfg.harmonics     <= 6'd0;
        end else if (w_wr) begin
            case (w_idx)
                mwo_pkg::REG_WAVEFORM:  r_cfg.waveform      <= i_pwdata[2:0];
                mwo_pkg::REG_FREQUENCY: r_cfg.frequency     <= i_pwdata[21:0];
                mwo_pkg::REG_AMPLITUDE: r_cfg.amplitude     <= i_pwdata[14:0];
                mwo_pkg::REG_OFFSET:    r_cfg.offset        <= $signed(i_pwdata[15:0]);
                mwo_pkg::REG_MOD_FREQ:  r_cfg.mod_frequency <= i_pwdata[21:0];
                mwo_pkg::REG_MOD_DEPTH: r_cfg.mod_depth     <= i_pwdata[23:0];
                mwo_pkg::REG_DUTY:      r_cfg.duty          <= i_pwdata[15:0];
                mwo_pkg::REG_HARMONICS: r_cfg.harmonics     <= i_pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            mwo_pkg::REG_WAVEFORM:  o_prdata = {29'd0, r_cfg.waveform};
            mwo_pkg::REG_FREQUENCY: o_prdata = {10'd0, r_cfg.frequency};
            mwo_pkg::REG_AMPLITUDE: o_prdata = {17'd0, r_cfg.amplitude};
            mwo_pkg::REG_OFFSET:    o_prdata = {16'd0, r_cfg.offset};
            mwo_pkg::REG_MOD_FREQ:  o_prdata = {10'd0, r_cfg.mod_frequency};
            mwo_pkg::REG_MOD_DEPTH: o_prdata = {8'd0, r_cfg.mod_depth};
            mwo_pkg::REG_DUTY:      o_prdata = {16'd0, r_cfg.duty};
            mwo_pkg::REG_HARMONICS: o_prdata = {26'd0, r_cfg.harmonics};
            default:                o_prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/multi_waveform_oscillator.sv =====
// Top level of the waveform oscillator: sequencer around one shared multiplier and the sine table.
//
// Usage: each transfer on the input stream (i_s_tvalid / o_s_tready / i_s_tdata) carries a
// 40-bit sample time in Q16.24 seconds. The block answers with one transfer on the output
// stream: tdata holds the signed 16-bit sample, tuser bit 0 is set when it was saturated.
// Waveform, frequencies, amplitude, offset, modulation, duty and harmonic count are set through
// the APB-style port by the user while no sample is in flight; the block does not enforce this.
// All arithmetic runs through one 33x25 multiplier and one sine table read port under a
// small sequencer, so the block takes one item at a time. Square and pulse skip the phase
// modulation; the harmonic saw takes longest, and its time grows with the harmonic limit.
// The next input transfer can be taken in the same cycle as the result becomes valid.
// The harmonic loop (table read, reciprocal multiply, accumulate) sets the worst case.
// A new item is accepted while the previous result still waits in the output register;
// if the receiver stalls, the sequencer holds its finished result until that register
// frees up. Reset is synchronous and restores the register defaults and an empty output.
`timescale 1ns / 1ps

module multi_waveform_oscillator #(
    parameter int SINE_TABLE_BITS = 10,
    parameter int MAX_HARMONICS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [39:0] sample_time
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [15:0] sample
    output logic [0:0]  o_m_tuser,   // [0] clipped
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    localparam int TB = SINE_TABLE_BITS;
    localparam int NB = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
    localparam int HW = NB + 1;
    localparam int SW = 24;

    typedef enum logic [23:0] {
        S_IDLE  = 24'h000001,
        S_BASE  = 24'h000002,
        S_MPH   = 24'h000004,
        S_MDF   = 24'h000008,
        S_M     = 24'h000010,
        S_MH    = 24'h000020,
        S_A     = 24'h000040,
        S_D0    = 24'h000080,
        S_D1    = 24'h000100,
        S_D2    = 24'h000200,
        S_MOD   = 24'h000400,
        S_SIN0  = 24'h000800,
        S_SIN1  = 24'h001000,
        S_TRI   = 24'h002000,
        S_SAWD  = 24'h004000,
        S_H0    = 24'h008000,
        S_H1    = 24'h010000,
        S_H2    = 24'h020000,
        S_SUMM  = 24'h040000,
        S_SAWW  = 24'h080000,
        S_WMUL  = 24'h100000,
        S_SCALE = 24'h200000,
        S_SQ    = 24'h400000,
        S_SAT   = 24'h800000
    } t_state;

    mwo_pkg::t_cfg w_cfg;

    t_state              r_state, n_state;
    logic [31:0]         r_t;
    logic [31:0]         r_base;
    logic [45:0]         r_m;
    logic signed [17:0]  r_s;
    logic [63:0]         r_acc;
    logic [46:0]         r_a;
    logic [31:0]         r_d;
    logic [31:0]         r_mod;
    logic [31:0]         r_ph;
    logic [NB-1:0]       r_n;
    logic [HW-1:0]       r_lim;
    logic signed [SW-1:0] r_sum;
    logic                r_hneg;
    logic signed [24:0]  r_wave;
    logic signed [23:0]  r_y;
    logic                r_ovalid;
    logic [15:0]         r_osample;
    logic                r_oclip;

    logic [31:0]         w_mul_a;
    logic signed [24:0]  w_mul_b;
    logic signed [57:0]  w_p;
    logic [TB-1:0]       w_rom_addr;
    logic signed [17:0]  w_rom_q;
    logic [16:0]         w_rom_mag;
    logic [16:0]         w_s_mag;
    logic [63:0]         w_wide;
    logic [31:0]         w_draw;
    logic signed [57:0]  w_rnd;
    logic [24:0]         w_rcp [MAX_HARMONICS];
    logic signed [18:0]  w_tri;
    logic signed [17:0]  w_sawd;
    logic [HW-1:0]       w_lim;
    logic [HW-1:0]       w_n_next;
    logic signed [23:0]  w_off;
    logic signed [23:0]  w_amp;
    logic                w_out_free;

    mwo_apb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (w_cfg)
    );

    mwo_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_p)
    );

    mwo_sine_rom #(
        .SINE_TABLE_BITS (TB)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_rom_q)
    );

    // Reciprocals rounded up to Q24; with a 17-bit dividend the truncated quotient is exact.
    for (genvar g = 0; g < MAX_HARMONICS; g++) begin : g_rcp
        if (g == 0) begin : g_zero
            assign w_rcp[g] = 25'd0;
        end else begin : g_val
            localparam int Rcp = ((1 << 24) + g - 1) / g;
            assign w_rcp[g] = 25'(Rcp);
        end
    end

    assign w_rom_mag = w_rom_q[17] ? 17'(-w_rom_q) : 17'(w_rom_q);
    assign w_s_mag   = r_s[17] ? 17'(-r_s) : 17'(r_s);
    assign w_rnd     = w_p + 58'sd32768;
    assign w_off     = 24'(w_cfg.offset);
    assign w_amp     = $signed({9'd0, w_cfg.amplitude});
    assign w_lim     = (int'(w_cfg.harmonics) > MAX_HARMONICS) ? HW'(MAX_HARMONICS)
                                                              : HW'(w_cfg.harmonics);
    assign w_n_next  = {1'b0, r_n} + HW'(1);
    assign w_out_free = !r_ovalid || i_m_tready;

    always_comb begin
        if (r_mod < 32'h4000_0000) begin
            w_tri = $signed({1'b0, r_mod[31:14]});
        end else if (r_mod < 32'hC000_0000) begin
            w_tri = 19'sd131072 - $signed({1'b0, r_mod[31:14]});
        end else begin
            w_tri = $signed({1'b0, r_mod[31:14]}) - 19'sd262144;
        end
    end

    assign w_sawd = $signed({1'b0, r_base[31:15]}) - 18'sd65536;

    always_comb begin
        w_wide = 64'd0;
        if (r_state == S_A || r_state == S_D2) begin
            w_wide = r_acc + {w_p[31:0], 32'd0};
        end
    end
    assign w_draw = w_wide[47:16];

    // Operand and table address selection for the shared units.
    always_comb begin
        w_mul_a    = 32'd0;
        w_mul_b    = 25'sd0;
        w_rom_addr = r_ph[31 -: TB];
        case (r_state)
            S_BASE: begin
                w_mul_a = r_t;
                w_mul_b = $signed({3'd0, w_cfg.frequency});
            end
            S_MPH: begin
                w_mul_a = r_t;
                w_mul_b = $signed({3'd0, w_cfg.mod_frequency});
            end
            S_MDF: begin
                w_rom_addr = w_p[31 -: TB];
                w_mul_a    = {10'd0, w_cfg.frequency};
                w_mul_b    = $signed({1'b0, w_cfg.mod_depth});
            end
            S_M: begin
                w_mul_a = w_p[31:0];
                w_mul_b = $signed({8'd0, w_rom_mag});
            end
            S_MH: begin
                w_mul_a = {18'd0, r_m[45:32]};
                w_mul_b = $signed({8'd0, w_s_mag});
            end
            S_D0: begin
                w_mul_a = r_a[31:0];
                w_mul_b = $signed({3'd0, mwo_pkg::INV_TWO_PI_Q24});
            end
            S_D1: begin
                w_mul_a = {17'd0, r_a[46:32]};
                w_mul_b = $signed({3'd0, mwo_pkg::INV_TWO_PI_Q24});
            end
            S_SIN0: begin
                w_rom_addr = r_mod[31 -: TB];
            end
            S_SIN1: begin
                w_mul_a = {17'd0, w_cfg.amplitude};
                w_mul_b = 25'(w_rom_q);
            end
            S_TRI: begin
                w_mul_a = {17'd0, w_cfg.amplitude};
                w_mul_b = 25'(w_tri);
            end
            S_SAWD: begin
                w_mul_a = {17'd0, w_cfg.amplitude};
                w_mul_b = 25'(w_sawd);
            end
            S_H0: begin
                w_rom_addr = r_ph[31 -: TB];
            end
            S_H1: begin
                w_mul_a = {7'd0, w_rcp[r_n]};
                w_mul_b = $signed({8'd0, w_rom_mag});
            end
            S_SUMM: begin
                w_mul_a = {16'd0, mwo_pkg::TWO_OVER_PI_Q16};
                w_mul_b = 25'(r_sum);
            end
            S_WMUL: begin
                w_mul_a = {17'd0, w_cfg.amplitude};
                w_mul_b = r_wave;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_s_tvalid) n_state = S_BASE;
            S_BASE:  n_state = S_MPH;
            S_MPH: begin
                case (w_cfg.waveform)
                    mwo_pkg::WAVE_SQUARE, mwo_pkg::WAVE_PULSE: n_state = S_SQ;
                    mwo_pkg::WAVE_SINE, mwo_pkg::WAVE_TRIANGLE, mwo_pkg::WAVE_SAW:
                        n_state = S_MDF;
                    default: n_state = S_SAT;
                endcase
            end
            S_MDF:   n_state = S_M;
            S_M:     n_state = S_MH;
            S_MH:    n_state = S_A;
            S_A:     n_state = S_D0;
            S_D0:    n_state = S_D1;
            S_D1:    n_state = S_D2;
            S_D2:    n_state = S_MOD;
            S_MOD: begin
                case (w_cfg.waveform)
                    mwo_pkg::WAVE_SINE:     n_state = S_SIN0;
                    mwo_pkg::WAVE_TRIANGLE: n_state = S_TRI;
                    default: begin
                        if (w_cfg.harmonics == 6'd0) begin
                            n_state = S_SAWD;
                        end else if (w_lim <= HW'(1)) begin
                            n_state = S_SUMM;
                        end else begin
                            n_state = S_H0;
                        end
                    end
                endcase
            end
            S_SIN0:  n_state = S_SIN1;
            S_SIN1:  n_state = S_SCALE;
            S_TRI:   n_state = S_SCALE;
            S_SAWD:  n_state = S_SCALE;
            S_H0:    n_state = S_H1;
            S_H1:    n_state = S_H2;
            S_H2:    n_state = (w_n_next >= r_lim) ? S_SUMM : S_H0;
            S_SUMM:  n_state = S_SAWW;
            S_SAWW:  n_state = S_WMUL;
            S_WMUL:  n_state = S_SCALE;
            S_SCALE: n_state = S_SAT;
            S_SQ:    n_state = S_SAT;
            S_SAT:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SAT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_t <= i_s_tdata[31:0];
                r_y <= 24'sd0;
            end
            S_MPH: begin
                r_base <= w_p[31:0];
            end
            S_M: begin
                r_m <= w_p[45:0];
                r_s <= w_rom_q;
            end
            S_MH:  r_acc <= 64'(w_p);
            S_A:   r_a <= w_wide[62:16];
            S_D1:  r_acc <= 64'(w_p);
            S_D2:  r_d <= r_s[17] ? (32'd0 - w_draw) : w_draw;
            S_MOD: begin
                r_mod <= r_base + r_d;
                r_ph  <= r_base + r_d;
                r_n   <= NB'(1);
                r_lim <= w_lim;
                r_sum <= '0;
            end
            S_H1: begin
                r_hneg <= w_rom_q[17];
            end
            S_H2: begin
                r_sum <= r_hneg ? (r_sum - SW'($signed({1'b0, w_p[40:24]})))
                                : (r_sum + SW'($signed({1'b0, w_p[40:24]})));
                r_ph  <= r_ph + r_mod;
                r_n   <= r_n + NB'(1);
            end
            S_SAWW: r_wave <= w_rnd[40:16];
            S_SCALE: begin
                if (w_cfg.waveform == mwo_pkg::WAVE_SAW) begin
                    r_y <= w_rnd[39:16];
                end else begin
                    r_y <= w_rnd[39:16] + w_off;
                end
            end
            S_SQ: begin
                if (r_base > {w_cfg.duty, 16'd0}) begin
                    r_y <= w_amp + w_off;
                end else if (w_cfg.waveform == mwo_pkg::WAVE_PULSE) begin
                    r_y <= w_off;
                end else begin
                    r_y <= w_off - w_amp;
                end
            end
            S_SAT: begin
                if (w_out_free) begin
                    if (r_y > 24'sd32767) begin
                        r_osample <= 16'h7FFF;
                        r_oclip   <= 1'b1;
                    end else if (r_y < -24'sd32768) begin
                        r_osample <= 16'h8000;
                        r_oclip   <= 1'b1;
                    end else begin
                        r_osample <= r_y[15:0];
                        r_oclip   <= 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_osample;
    assign o_m_tuser  = r_oclip;

endmodule

// ===== src/mwo_checker.sv =====
// Port-level checks for the waveform oscillator, bound to the top level.
`timescale 1ns / 1ps

module mwo_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic [0:0]  o_m_tuser,
    input logic        o_pready
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_ready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n) o_pready)
        else $error("pready dropped");

    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == 16'h7FFF || o_m_tdata == 16'h8000))
        else $error("clipped sample not at a rail");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tuser)))
        else $error("stalled transfer changed");

endmodule

bind multi_waveform_oscillator mwo_checker u_mwo_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_pready   (o_pready)
);
